[design/hsl_pkg.sv]
// hsl_pkg: widths, constants and inter-stage types for the HSL to RGB565 converter.
// Used by hsl_front, hsl_mix, hsl_scale and hsl_to_rgb565_top. No dependencies.

package hsl_pkg;

    localparam int HUE_W   = 9;
    localparam int CH_W    = 8;
    localparam int PROD_W  = 16;  // a * s
    localparam int TRI_W   = 6;   // distance inside sector, 0..60
    localparam int UNIT_W  = 23;  // channel value in units of 1/7803000
    localparam int RECIP_W = 25;
    localparam int WIDE_W  = UNIT_W + RECIP_W;
    localparam int RECIP_SHIFT = 39;
    localparam int PACK_W  = 16;
    localparam int NUM_CH  = 3;

    localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
    localparam logic [HUE_W-1:0] HUE_S1    = 9'd60;
    localparam logic [HUE_W-1:0] HUE_S2    = 9'd120;
    localparam logic [HUE_W-1:0] HUE_S3    = 9'd180;
    localparam logic [HUE_W-1:0] HUE_S4    = 9'd240;
    localparam logic [HUE_W-1:0] HUE_S5    = 9'd300;
    localparam logic [HUE_W-1:0] LIGHT_MID = 9'd255;

    localparam logic [UNIT_W-1:0] CHROMA_MUL = 23'd120;
    localparam logic [UNIT_W-1:0] OFFSET_MUL = 23'd60;
    localparam logic [UNIT_W-1:0] LIGHT_MUL  = 23'd30600;
    // ceil(2^39 / 30600): exact floor division for every value below 2^23
    localparam logic [RECIP_W-1:0] RECIP     = 25'd17965877;

    localparam logic [CH_W-1:0] LEVEL_MAX = 8'd255;

    // hue sectors
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    // channel lanes
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    typedef logic [UNIT_W-1:0] t_unit;

    typedef struct packed {
        logic [2:0]        sector;
        logic [TRI_W-1:0]  tri_pos;
        logic [PROD_W-1:0] as_prod;
        logic [CH_W-1:0]   light;
    } t_front;

    typedef struct packed {
        logic [NUM_CH-1:0][UNIT_W-1:0] n;
    } t_mix;

endpackage

[design/hsl_front.sv]
// hsl_front: hue wrap, lightness fold, sector/triangle decode and a*s product.
// Two register stages. Depends on hsl_pkg.

module hsl_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [hsl_pkg::HUE_W-1:0]     i_hue_deg,
    input  logic [hsl_pkg::CH_W-1:0]      i_saturation,
    input  logic [hsl_pkg::CH_W-1:0]      i_lightness,
    output logic                          o_valid,
    output hsl_pkg::t_front               o_front
);

    logic                       r_v1;
    logic [hsl_pkg::HUE_W-1:0]  r_h1;
    logic [hsl_pkg::CH_W-1:0]   r_a1;
    logic [hsl_pkg::CH_W-1:0]   r_s1;
    logic [hsl_pkg::CH_W-1:0]   r_l1;

    logic [hsl_pkg::HUE_W-1:0]  n_h1;
    logic [hsl_pkg::HUE_W-1:0]  twol;
    logic [hsl_pkg::HUE_W-1:0]  fold_dist;
    logic [hsl_pkg::CH_W-1:0]   n_a1;

    logic                       r_v2;
    hsl_pkg::t_front            r_f2;
    hsl_pkg::t_front            n_f2;
    logic [hsl_pkg::HUE_W-1:0]  tri_full;

    // stage 1: wrap hue into 0..359, A = 255 - |2L - 255|
    always_comb begin
        n_h1 = (i_hue_deg >= hsl_pkg::HUE_FULL) ? i_hue_deg - hsl_pkg::HUE_FULL : i_hue_deg;
        twol = {i_lightness, 1'b0};
        fold_dist = (twol >= hsl_pkg::LIGHT_MID) ? twol - hsl_pkg::LIGHT_MID
                                                 : hsl_pkg::LIGHT_MID - twol;
        n_a1 = hsl_pkg::LEVEL_MAX - fold_dist[hsl_pkg::CH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h1 <= n_h1;
        r_a1 <= n_a1;
        r_s1 <= i_saturation;
        r_l1 <= i_lightness;
    end

    // stage 2: sector and distance to nearest multiple of 120 degrees, product a*s
    always_comb begin
        if (r_h1 < hsl_pkg::HUE_S1) begin
            n_f2.sector = hsl_pkg::SEC_RED_YEL;
            tri_full    = r_h1;
        end else if (r_h1 < hsl_pkg::HUE_S2) begin
            n_f2.sector = hsl_pkg::SEC_YEL_GRN;
            tri_full    = hsl_pkg::HUE_S2 - r_h1;
        end else if (r_h1 < hsl_pkg::HUE_S3) begin
            n_f2.sector = hsl_pkg::SEC_GRN_CYN;
            tri_full    = r_h1 - hsl_pkg::HUE_S2;
        end else if (r_h1 < hsl_pkg::HUE_S4) begin
            n_f2.sector = hsl_pkg::SEC_CYN_BLU;
            tri_full    = hsl_pkg::HUE_S4 - r_h1;
        end else if (r_h1 < hsl_pkg::HUE_S5) begin
            n_f2.sector = hsl_pkg::SEC_BLU_MAG;
            tri_full    = r_h1 - hsl_pkg::HUE_S4;
        end else begin
            n_f2.sector = hsl_pkg::SEC_MAG_RED;
            tri_full    = hsl_pkg::HUE_FULL - r_h1;
        end
        n_f2.tri_pos = tri_full[hsl_pkg::TRI_W-1:0];
        n_f2.as_prod = hsl_pkg::PROD_W'(r_a1) * hsl_pkg::PROD_W'(r_s1);
        n_f2.light   = r_l1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2 <= n_f2;
    end

    assign o_valid = r_v2;
    assign o_front = r_f2;

endmodule

[design/hsl_mix.sv]
// hsl_mix: chroma, secondary and offset products, then sector routing and offset add.
// Two register stages. Depends on hsl_pkg.

module hsl_mix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hsl_pkg::t_front i_front,
    output logic            o_valid,
    output hsl_pkg::t_mix   o_mix
);

    logic                r_v3;
    hsl_pkg::t_unit      r_c3;
    hsl_pkg::t_unit      r_x3;
    hsl_pkg::t_unit      r_lm3;
    hsl_pkg::t_unit      r_pm3;
    logic [2:0]          r_sec3;

    logic                r_v4;
    hsl_pkg::t_mix       r_m4;
    hsl_pkg::t_mix       n_m4;
    hsl_pkg::t_unit      moff;
    hsl_pkg::t_unit      comp_r;
    hsl_pkg::t_unit      comp_g;
    hsl_pkg::t_unit      comp_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    // stage 3: C = p*120, X = p*2*tri, L term and half-chroma term
    always_ff @(posedge i_clk) begin
        r_c3   <= hsl_pkg::UNIT_W'(i_front.as_prod) * hsl_pkg::CHROMA_MUL;
        r_x3   <= hsl_pkg::UNIT_W'(i_front.as_prod)
                  * hsl_pkg::UNIT_W'({i_front.tri_pos, 1'b0});
        r_lm3  <= hsl_pkg::UNIT_W'(i_front.light) * hsl_pkg::LIGHT_MUL;
        r_pm3  <= hsl_pkg::UNIT_W'(i_front.as_prod) * hsl_pkg::OFFSET_MUL;
        r_sec3 <= i_front.sector;
    end

    // stage 4: route C and X by sector, add m (never negative since A <= 2L)
    always_comb begin
        moff   = r_lm3 - r_pm3;
        comp_r = '0;
        comp_g = '0;
        comp_b = '0;
        case (r_sec3)
            hsl_pkg::SEC_RED_YEL: begin
                comp_r = r_c3;
                comp_g = r_x3;
            end
            hsl_pkg::SEC_YEL_GRN: begin
                comp_r = r_x3;
                comp_g = r_c3;
            end
            hsl_pkg::SEC_GRN_CYN: begin
                comp_g = r_c3;
                comp_b = r_x3;
            end
            hsl_pkg::SEC_CYN_BLU: begin
                comp_g = r_x3;
                comp_b = r_c3;
            end
            hsl_pkg::SEC_BLU_MAG: begin
                comp_r = r_x3;
                comp_b = r_c3;
            end
            default: begin
                comp_r = r_c3;
                comp_b = r_x3;
            end
        endcase
        n_m4.n[hsl_pkg::CH_R] = comp_r + moff;
        n_m4.n[hsl_pkg::CH_G] = comp_g + moff;
        n_m4.n[hsl_pkg::CH_B] = comp_b + moff;
    end

    always_ff @(posedge i_clk) begin
        r_m4 <= n_m4;
    end

    assign o_valid = r_v4;
    assign o_mix   = r_m4;

endmodule

[design/hsl_scale.sv]
// hsl_scale: divide each channel by 30600 through a reciprocal multiply, clamp, pack 565.
// Two register stages, output registers included. Depends on hsl_pkg.

module hsl_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  hsl_pkg::t_mix                i_mix,
    output logic                         o_valid,
    output logic [hsl_pkg::CH_W-1:0]     o_red_level,
    output logic [hsl_pkg::CH_W-1:0]     o_green_level,
    output logic [hsl_pkg::CH_W-1:0]     o_blue_level,
    output logic [hsl_pkg::PACK_W-1:0]   o_packed_565
);

    logic                                          r_v5;
    logic [hsl_pkg::NUM_CH-1:0][hsl_pkg::WIDE_W-1:0] r_pr5;

    logic                                          r_v6;
    logic [hsl_pkg::NUM_CH-1:0][hsl_pkg::CH_W-1:0] r_lvl6;
    logic [hsl_pkg::NUM_CH-1:0][hsl_pkg::CH_W-1:0] n_lvl6;
    logic [hsl_pkg::NUM_CH-1:0][hsl_pkg::WIDE_W-hsl_pkg::RECIP_SHIFT-1:0] quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
        end
    end

    // stage 5: n * ceil(2^39/30600)
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < hsl_pkg::NUM_CH; k++) begin
            r_pr5[k] <= hsl_pkg::WIDE_W'(i_mix.n[k]) * hsl_pkg::WIDE_W'(hsl_pkg::RECIP);
        end
    end

    // stage 6: drop the fraction, clamp to 8 bits
    always_comb begin
        for (int k = 0; k < hsl_pkg::NUM_CH; k++) begin
            quot[k]   = r_pr5[k][hsl_pkg::WIDE_W-1:hsl_pkg::RECIP_SHIFT];
            n_lvl6[k] = (quot[k] > (hsl_pkg::WIDE_W - hsl_pkg::RECIP_SHIFT)'(hsl_pkg::LEVEL_MAX))
                        ? hsl_pkg::LEVEL_MAX : quot[k][hsl_pkg::CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl6 <= n_lvl6;
    end

    assign o_valid       = r_v6;
    assign o_red_level   = r_lvl6[hsl_pkg::CH_R];
    assign o_green_level = r_lvl6[hsl_pkg::CH_G];
    assign o_blue_level  = r_lvl6[hsl_pkg::CH_B];
    assign o_packed_565  = {r_lvl6[hsl_pkg::CH_R][7:3],
                            r_lvl6[hsl_pkg::CH_G][7:2],
                            r_lvl6[hsl_pkg::CH_B][7:3]};

endmodule

[design/hsl_to_rgb565_top.sv]
// hsl_to_rgb565_top: HSL to RGB888 / RGB565 converter, six-stage pipeline.
// Instantiates hsl_front, hsl_mix, hsl_scale; depends on hsl_pkg.
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     start & !busy        i_hue_deg[8:0], i_saturation[7:0], i_lightness[7:0]
//  result    o_done (one cycle)   o_red_level, o_green_level, o_blue_level,
//                                 o_packed_565[15:0]
//
//  One beat is accepted every cycle; busy is held low.
//  An accepted beat reaches the result ports, with o_done high, through six
//  register stages: hue/lightness fold, a*s, chroma products, sector add,
//  reciprocal multiply, clamp and pack.
//  Synchronous active-low reset clears the valid bits only; no result is
//  lost since the receiver takes every beat as it appears.

module hsl_to_rgb565_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [hsl_pkg::HUE_W-1:0]     i_hue_deg,
    input  logic [hsl_pkg::CH_W-1:0]      i_saturation,
    input  logic [hsl_pkg::CH_W-1:0]      i_lightness,
    output logic                          o_done,
    output logic [hsl_pkg::CH_W-1:0]      o_red_level,
    output logic [hsl_pkg::CH_W-1:0]      o_green_level,
    output logic [hsl_pkg::CH_W-1:0]      o_blue_level,
    output logic [hsl_pkg::PACK_W-1:0]    o_packed_565
);

    logic            in_beat;
    logic            front_valid;
    hsl_pkg::t_front front_data;
    logic            mix_valid;
    hsl_pkg::t_mix   mix_data;

    assign busy    = 1'b0;
    assign in_beat = start & ~busy;

    hsl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_beat),
        .i_hue_deg    (i_hue_deg),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_valid      (front_valid),
        .o_front      (front_data)
    );

    hsl_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_front (front_data),
        .o_valid (mix_valid),
        .o_mix   (mix_data)
    );

    hsl_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (mix_valid),
        .i_mix         (mix_data),
        .o_valid       (o_done),
        .o_red_level   (o_red_level),
        .o_green_level (o_green_level),
        .o_blue_level  (o_blue_level),
        .o_packed_565  (o_packed_565)
    );

endmodule
